/* hw/rtl/ubsa_pkg.sv */
// Shared types and constants of the unit bump suballocator.
// Used by the channel interfaces and the top level.
package ubsa_pkg;

	localparam int unsigned UNIT_BYTES_DEF  = 65536;
	localparam int unsigned NUM_UNITS_DEF   = 16;
	localparam int unsigned ORDER_DEPTH_DEF = 32;

	localparam int unsigned SIZE_W  = 24;
	localparam int unsigned ADDR_W  = 20;
	localparam int unsigned ROUND_W = SIZE_W + 1;
	localparam int unsigned LIVE_W  = 13;

	localparam logic [LIVE_W-1:0]  LIVE_MAX   = 13'h1FFF;
	localparam logic [ROUND_W-1:0] GRAIN_MASK = 25'hF;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_NO_UNIT   = 2'd2,
		ST_BAD_FREE  = 2'd3
	} status_t;

endpackage

/* hw/rtl/ubsa_req_if.sv */
// Request channel of the unit bump suballocator: valid/ready plus payload.
// Depends on ubsa_pkg for the command type and field widths.
interface ubsa_req_if;
	logic                          valid;
	logic                          ready;
	ubsa_pkg::cmd_t                command;
	logic [ubsa_pkg::SIZE_W-1:0]   size_bytes;
	logic [ubsa_pkg::ADDR_W-1:0]   address;

	modport source (output valid, output command, output size_bytes, output address,
		input ready);
	modport sink (input valid, input command, input size_bytes, input address,
		output ready);
endinterface

/* hw/rtl/ubsa_rsp_if.sv */
// Response channel of the unit bump suballocator: valid/ready plus payload.
// Depends on ubsa_pkg for the status type and field widths.
interface ubsa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ubsa_pkg::ADDR_W-1:0]   granted_address;
	ubsa_pkg::status_t             status;

	modport source (output valid, output granted_address, output status, input ready);
	modport sink (input valid, input granted_address, input status, output ready);
endinterface

/* hw/rtl/ubsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependencies.
module ubsa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/unit_bump_suballocator_top.sv */
// Unit bump suballocator: alloc/free over a pool of fixed-size units.
// Depends on ubsa_pkg, ubsa_req_if, ubsa_rsp_if and ubsa_ram.
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+-------------------------------------
//   req     | in  | valid/ready | command, size_bytes, address
//   rsp     | out | valid/ready | granted_address, status
//
// One request at a time through a small sequencer around a multiplier shared by the allocate states.
// Allocate: read the order-stack top and check the fit there; a fresh unit is opened
// when it does not fit. Free: the unit index comes from a constant reciprocal multiply
// in one step, then the unit's counters are read and checked. A free that closes its unit
// checks the order-stack top and examines entries below it; each of those waits on the order RAM read.
// Requests rejected on arrival (too large, address past the pool) go straight to the response.
// Reset is immediate: unit state sits behind in-use flags, no clearing pass.
// A finished response sits in the output register; the next request is taken
// while it waits, and the block only holds in its last step if it is still full.
module unit_bump_suballocator_top #(
	parameter int unsigned UNIT_BYTES  = ubsa_pkg::UNIT_BYTES_DEF,
	parameter int unsigned NUM_UNITS   = ubsa_pkg::NUM_UNITS_DEF,
	parameter int unsigned ORDER_DEPTH = ubsa_pkg::ORDER_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ubsa_req_if.sink     req,
	ubsa_rsp_if.source   rsp
);

	localparam int unsigned UW  = $clog2(NUM_UNITS);
	localparam int unsigned FW  = $clog2(UNIT_BYTES + 1);
	localparam int unsigned SCW = $clog2(NUM_UNITS + 1);
	localparam int unsigned OPW = $clog2(ORDER_DEPTH);
	localparam int unsigned OCW = $clog2(ORDER_DEPTH + 1);
	localparam int unsigned PW  = UW + FW;
	localparam int unsigned AW  = ubsa_pkg::ADDR_W;
	localparam int unsigned LW  = ubsa_pkg::LIVE_W;
	localparam int unsigned RW  = ubsa_pkg::ROUND_W;
	localparam longint unsigned POOL_BYTES = longint'(NUM_UNITS) * longint'(UNIT_BYTES);
	// The reciprocal is rounded up with AW extra bits, which makes the quotient
	// exact for every address of AW bits.
	localparam int unsigned RSH = AW + $clog2(UNIT_BYTES);
	localparam longint unsigned RECIP =
		((64'd1 << RSH) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_A_TOP  = 11'b000_0000_0010,
		S_A_FIT  = 11'b000_0000_0100,
		S_A_OPEN = 11'b000_0000_1000,
		S_F_DIV  = 11'b000_0001_0000,
		S_F_RD   = 11'b000_0010_0000,
		S_F_CHK  = 11'b000_0100_0000,
		S_F_TOP  = 11'b000_1000_0000,
		S_F_READ = 11'b001_0000_0000,
		S_F_SCAN = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	state_t                  state_q;
	logic [NUM_UNITS-1:0]    in_use_q;
	logic [OCW-1:0]          order_count_q;
	logic [OPW-1:0]          order_wr_q;
	logic [SCW-1:0]          slot_count_q;
	logic [SCW-1:0]          lowmark_q;
	logic [UW-1:0]           unit_q;
	logic [FW-1:0]           bytes_q;
	logic [AW-1:0]           addr_q;
	logic [AW-1:0]           res_addr_q;
	ubsa_pkg::status_t       res_status_q;
	logic                    out_valid_q;
	logic [AW-1:0]           out_addr_q;
	ubsa_pkg::status_t       out_status_q;

	logic [OPW-1:0]          order_top;
	logic [RW-1:0]           rounded;
	logic                    too_large;
	logic [UW-1:0]           new_unit;
	logic [UW-1:0]           mul_a;
	logic [PW-1:0]           prod;
	logic [63:0]             quot_full;
	logic [FW:0]             fill_sum;
	logic                    fits;
	logic [AW-1:0]           granted_sum;
	logic [LW-1:0]           live_dec;
	logic                    bad_free;
	logic                    load_out;

	logic                    unit_we;
	logic [UW-1:0]           unit_waddr;
	logic [UW-1:0]           unit_raddr;
	logic [FW-1:0]           fill_wdata;
	logic [FW-1:0]           fill_rdata;
	logic                    live_we;
	logic [LW-1:0]           live_wdata;
	logic [LW-1:0]           live_rdata;
	logic [UW-1:0]           order_rdata;
	logic                    slot_we;
	logic [UW-1:0]           slot_rdata;

	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = out_valid_q;
	assign rsp.granted_address = out_addr_q;
	assign rsp.status          = out_status_q;

	always_comb begin
		order_top = (order_wr_q == '0) ? OPW'(ORDER_DEPTH - 1) : order_wr_q - 1'b1;
		rounded   = (RW'(req.size_bytes) + ubsa_pkg::GRAIN_MASK) & ~ubsa_pkg::GRAIN_MASK;
		too_large = 32'(rounded) >= 32'(UNIT_BYTES);

		// Slots below the low-water mark were never pushed back; their units are computed
		// from the slot index instead of read, which pops unit 0 first.
		if (SCW'(slot_count_q) < lowmark_q) begin
			new_unit = UW'(NUM_UNITS - 1) - UW'(slot_count_q);
		end else begin
			new_unit = slot_rdata;
		end

		if (state_q == S_A_OPEN) begin
			mul_a = new_unit;
		end else begin
			mul_a = unit_q;
		end
		prod      = PW'(mul_a) * PW'(UNIT_BYTES);
		quot_full = (64'(addr_q) * RECIP) >> RSH;

		fill_sum = (FW+1)'(fill_rdata) + (FW+1)'(bytes_q);
		fits     = (order_count_q != '0) && in_use_q[unit_q]
			&& (fill_sum <= (FW+1)'(UNIT_BYTES))
			&& (fill_rdata < FW'(UNIT_BYTES))
			&& (live_rdata < ubsa_pkg::LIVE_MAX);
		granted_sum = AW'(prod) + ((state_q == S_A_OPEN) ? '0 : AW'(fill_rdata));
		live_dec    = live_rdata - 1'b1;
		bad_free    = !in_use_q[unit_q] || (live_rdata == '0);
		load_out    = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

		unit_raddr = (state_q == S_A_TOP) ? order_rdata : unit_q;
		unit_waddr = (state_q == S_A_OPEN) ? new_unit : unit_q;
		unit_we    = ((state_q == S_A_FIT) && fits) || (state_q == S_A_OPEN);
		fill_wdata = (state_q == S_A_OPEN) ? bytes_q : fill_sum[FW-1:0];
		live_we    = unit_we || ((state_q == S_F_CHK) && !bad_free);
		if (state_q == S_A_OPEN) begin
			live_wdata = LW'(1);
		end else if (state_q == S_F_CHK) begin
			live_wdata = live_dec;
		end else begin
			live_wdata = live_rdata + 1'b1;
		end
		slot_we = (state_q == S_F_CHK) && !bad_free && (live_dec == '0)
			&& (slot_count_q < SCW'(NUM_UNITS));
	end

	ubsa_ram #(.WIDTH(FW), .DEPTH(NUM_UNITS)) u_fill_ram (
		.clk   (clk),
		.we    (unit_we),
		.waddr (unit_waddr),
		.wdata (fill_wdata),
		.raddr (unit_raddr),
		.rdata (fill_rdata)
	);

	ubsa_ram #(.WIDTH(LW), .DEPTH(NUM_UNITS)) u_live_ram (
		.clk   (clk),
		.we    (live_we),
		.waddr (unit_waddr),
		.wdata (live_wdata),
		.raddr (unit_raddr),
		.rdata (live_rdata)
	);

	ubsa_ram #(.WIDTH(UW), .DEPTH(ORDER_DEPTH)) u_order_ram (
		.clk   (clk),
		.we    (state_q == S_A_OPEN),
		.waddr (order_wr_q),
		.wdata (new_unit),
		.raddr (order_top),
		.rdata (order_rdata)
	);

	ubsa_ram #(.WIDTH(UW), .DEPTH(NUM_UNITS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (UW'(slot_count_q)),
		.wdata (unit_q),
		.raddr (UW'(slot_count_q - 1'b1)),
		.rdata (slot_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			in_use_q      <= '0;
			order_count_q <= '0;
			order_wr_q    <= '0;
			slot_count_q  <= SCW'(NUM_UNITS);
			lowmark_q     <= SCW'(NUM_UNITS);
			out_valid_q   <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						res_addr_q   <= '0;
						res_status_q <= ubsa_pkg::ST_OK;
						bytes_q      <= FW'(rounded);
						addr_q       <= req.address;
						unit_q       <= '0;
						if (req.command == ubsa_pkg::CMD_ALLOC) begin
							if (too_large) begin
								res_status_q <= ubsa_pkg::ST_TOO_LARGE;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_A_TOP;
							end
						end else if (64'(req.address) >= POOL_BYTES) begin
							res_status_q <= ubsa_pkg::ST_BAD_FREE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_F_DIV;
						end
					end
				end
				S_A_TOP: begin
					unit_q  <= order_rdata;
					state_q <= S_A_FIT;
				end
				S_A_FIT: begin
					if (fits) begin
						res_addr_q <= granted_sum;
						state_q    <= S_DONE;
					end else if (slot_count_q == '0) begin
						res_status_q <= ubsa_pkg::ST_NO_UNIT;
						state_q      <= S_DONE;
					end else begin
						slot_count_q <= slot_count_q - 1'b1;
						state_q      <= S_A_OPEN;
					end
				end
				S_A_OPEN: begin
					in_use_q[new_unit] <= 1'b1;
					order_wr_q <= (order_wr_q == OPW'(ORDER_DEPTH - 1)) ? '0
						: order_wr_q + 1'b1;
					if (order_count_q < OCW'(ORDER_DEPTH)) begin
						order_count_q <= order_count_q + 1'b1;
					end
					if (slot_count_q < lowmark_q) begin
						lowmark_q <= slot_count_q;
					end
					res_addr_q <= granted_sum;
					state_q    <= S_DONE;
				end
				S_F_DIV: begin
					// The address was checked against the pool size, so the
					// quotient always names a real unit.
					unit_q  <= quot_full[UW-1:0];
					state_q <= S_F_RD;
				end
				S_F_RD: begin
					state_q <= S_F_CHK;
				end
				S_F_CHK: begin
					if (bad_free) begin
						res_status_q <= ubsa_pkg::ST_BAD_FREE;
						state_q      <= S_DONE;
					end else if (live_dec == '0) begin
						in_use_q[unit_q] <= 1'b0;
						if (slot_count_q < SCW'(NUM_UNITS)) begin
							slot_count_q <= slot_count_q + 1'b1;
						end
						state_q <= (order_count_q != '0) ? S_F_TOP : S_DONE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_F_TOP: begin
					if (order_rdata == unit_q) begin
						order_wr_q    <= order_top;
						order_count_q <= order_count_q - 1'b1;
						state_q <= (order_count_q != OCW'(1)) ? S_F_READ : S_DONE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_F_READ: begin
					state_q <= S_F_SCAN;
				end
				S_F_SCAN: begin
					// Entries below the freed unit whose units are closed are stale.
					if (!in_use_q[order_rdata]) begin
						order_wr_q    <= order_top;
						order_count_q <= order_count_q - 1'b1;
						state_q <= (order_count_q != OCW'(1)) ? S_F_READ : S_DONE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						out_addr_q   <= res_addr_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Every unit is either open or sitting on the free-slot stack.
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		($countones(in_use_q) + int'(slot_count_q)) == int'(NUM_UNITS))
		else $error("open units and free slots do not add up to the pool size");

	a_order_bound: assert property (@(posedge clk) disable iff (!arst_n)
		order_count_q <= OCW'(ORDER_DEPTH))
		else $error("order stack count beyond its depth");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ubsa_pkg::ST_OK)) |-> (rsp.granted_address == '0))
		else $error("failed request carries a granted address");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != S_IDLE))
		else $error("request transfer did not start the sequencer");

endmodule
